@@ hw/rtl/lru_key_value_cache_unit_assert.svh @@
// Assertion macros for the LRU key-value cache unit.
// Included by the RTL modules that carry concurrent checks.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define LKVC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: lbl");
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");
`else
`define LKVC_ASSERT(lbl, clk, rst_n, prop)
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/lkvc_pkg.sv @@
// Shared types and constants for the LRU key-value cache unit.
// No dependencies; used by the controller, datapath and top level.
package lkvc_pkg;

	localparam int CAPACITY_DEF      = 64;
	localparam int PAYLOAD_WIDTH_DEF = 64;
	localparam logic [6:0] MAXENT_RESET = 7'd64;

	localparam int KEY_W  = 64;
	localparam int CNT_W  = 32;
	localparam int SIZE_W = 7;
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 240;

	typedef enum logic [1:0] {
		OP_GET   = 2'd0,
		OP_PUT   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SDRAIN,
		ST_RESOLVE,
		ST_UPD,
		ST_UDRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic decide;
		logic upd;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic new_lookup;
		logic cnt_last;
		logic need_upd;
		logic out_free;
	} sts_t;

endpackage

@@ hw/rtl/lkvc_ctrl.sv @@
// Operation sequencer for the LRU key-value cache unit.
// Depends on lkvc_pkg; drives command strobes into lkvc_dp.
module lkvc_ctrl import lkvc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = sts.new_lookup ? ST_SCAN : ST_FIN;
			end
			ST_SCAN: begin
				if (sts.cnt_last) state_d = ST_SDRAIN;
			end
			ST_SDRAIN:  state_d = ST_RESOLVE;
			ST_RESOLVE: state_d = sts.need_upd ? ST_UPD : ST_FIN;
			ST_UPD: begin
				if (sts.cnt_last) state_d = ST_UDRAIN;
			end
			ST_UDRAIN:  state_d = ST_FIN;
			ST_FIN: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN:    cmd.scan   = 1'b1;
			ST_RESOLVE: cmd.decide = 1'b1;
			ST_UPD:     cmd.upd    = 1'b1;
			ST_FIN:     cmd.commit = sts.out_free;
			default:    cmd        = '0;
		endcase
	end

endmodule

@@ hw/rtl/lkvc_dp.sv @@
// Datapath of the LRU key-value cache unit: entry memories, valid bits,
// scan accumulators, counters and the result register. Depends on lkvc_pkg.
module lkvc_dp import lkvc_pkg::*; #(
	parameter int CAPACITY      = CAPACITY_DEF,
	parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic [1:0]            in_op,
	input  logic                  cfg_we,
	input  logic [SIZE_W-1:0]     cfg_wdata,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OW = $clog2(CAPACITY + 1);
	localparam int PW = PAYLOAD_WIDTH;

	// entry stores
	logic [KEY_W-1:0] key_mem  [CAPACITY];
	logic [PW-1:0]    pay_mem  [CAPACITY];
	logic [AW-1:0]    rank_mem [CAPACITY];
	logic [CAPACITY-1:0] valid_q;

	logic [SIZE_W-1:0] max_q;
	logic [OW-1:0]     occ_q;
	logic [CNT_W-1:0]  gets_q, puts_q, hits_q, misses_q, evicts_q;

	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [PW-1:0]    pay_q;
	logic [AW-1:0]    cnt_q;

	logic             scan_s1, upd_s1;
	logic [AW-1:0]    idx_s1;
	logic [KEY_W-1:0] key_rd_s1;
	logic [AW-1:0]    rank_rd_s1;

	logic          found_q, old_q, free_found_q;
	logic [AW-1:0] fidx_q, frank_q, oidx_q, orank_q, free_q;

	logic          evict_q, all_q;
	logic [AW-1:0] tgt_q;
	logic [PW-1:0] pay_rd_q;

	logic          out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// decision terms
	logic [31:0] lim;
	logic        evict_d;
	logic        v_s1, vpost_s1;
	logic        rk_we;
	logic [AW-1:0] rk_wd;

	always_comb begin
		if (max_q == '0) lim = 32'd1;
		else if (32'(max_q) > 32'(CAPACITY)) lim = 32'(CAPACITY);
		else lim = 32'(max_q);
		evict_d = (op_q == OP_PUT) && !found_q && (32'(occ_q) >= lim);
	end

	assign v_s1     = valid_q[idx_s1];
	assign vpost_s1 = v_s1 && !(evict_q && idx_s1 == oidx_q);

	always_comb begin
		rk_we = 1'b0;
		rk_wd = rank_rd_s1;
		if (upd_s1) begin
			if (idx_s1 == tgt_q) begin
				rk_we = 1'b1;
				rk_wd = '0;
			end else if (vpost_s1 && (all_q || rank_rd_s1 < frank_q)) begin
				rk_we = 1'b1;
				rk_wd = rank_rd_s1 + AW'(1);
			end
		end
	end

	assign sts.new_lookup = (in_op == OP_GET) || (in_op == OP_PUT);
	assign sts.cnt_last   = (cnt_q == AW'(CAPACITY - 1));
	assign sts.need_upd   = (op_q == OP_PUT) || found_q;
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAXENT_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// operation registers and sweep counter
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(in_op);
			key_q <= in_data[KEY_W-1:0];
			pay_q <= in_data[KEY_W +: PW];
		end
		if (cmd.load || cmd.decide) cnt_q <= '0;
		else if (cmd.scan || cmd.upd) cnt_q <= cnt_q + AW'(1);
		idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= 1'b0;
			upd_s1  <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan;
			upd_s1  <= cmd.upd;
		end
	end

	// key and rank memories: one read, one write per cycle
	always_ff @(posedge clk) begin
		key_rd_s1  <= key_mem[cnt_q];
		rank_rd_s1 <= rank_mem[cnt_q];
		if (rk_we) rank_mem[idx_s1] <= rk_wd;
		if (cmd.commit && op_q == OP_PUT && !found_q) key_mem[tgt_q] <= key_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) pay_rd_q <= pay_mem[fidx_q];
		if (cmd.commit && op_q == OP_PUT) pay_mem[tgt_q] <= pay_q;
	end

	// scan accumulators: match, oldest entry, first free slot
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			found_q      <= 1'b0;
			old_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (scan_s1) begin
			if (v_s1 && key_rd_s1 == key_q) begin
				found_q <= 1'b1;
				fidx_q  <= idx_s1;
				frank_q <= rank_rd_s1;
			end
			if (v_s1 && (!old_q || rank_rd_s1 >= orank_q)) begin
				old_q   <= 1'b1;
				oidx_q  <= idx_s1;
				orank_q <= rank_rd_s1;
			end
			if (!v_s1 && !free_found_q) begin
				free_found_q <= 1'b1;
				free_q       <= idx_s1;
			end
		end
		if (cmd.decide) begin
			evict_q <= evict_d;
			all_q   <= !found_q;
			tgt_q   <= found_q ? fidx_q : (evict_d ? oidx_q : free_q);
		end
	end

	// commit: valid bits, occupancy, counters, result
	logic [OW-1:0]    occ_new;
	logic [CNT_W-1:0] gets_n, puts_n, hits_n, misses_n, evicts_n;
	logic             hit_n, ev_n;

	always_comb begin
		occ_new  = occ_q;
		gets_n   = gets_q;
		puts_n   = puts_q;
		hits_n   = hits_q;
		misses_n = misses_q;
		evicts_n = evicts_q;
		hit_n    = 1'b0;
		ev_n     = 1'b0;
		case (op_q)
			OP_GET: begin
				gets_n = gets_q + CNT_W'(1);
				hit_n  = found_q;
				if (found_q) hits_n = hits_q + CNT_W'(1);
				else misses_n = misses_q + CNT_W'(1);
			end
			OP_PUT: begin
				puts_n = puts_q + CNT_W'(1);
				if (!found_q) begin
					ev_n = evict_q;
					if (evict_q) evicts_n = evicts_q + CNT_W'(1);
					else occ_new = occ_q + OW'(1);
				end
			end
			OP_CLEAR: occ_new = '0;
			default:  occ_new = occ_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			occ_q       <= '0;
			gets_q      <= '0;
			puts_q      <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				occ_q    <= occ_new;
				gets_q   <= gets_n;
				puts_q   <= puts_n;
				hits_q   <= hits_n;
				misses_q <= misses_n;
				evicts_q <= evicts_n;
				if (op_q == OP_CLEAR) begin
					valid_q <= '0;
				end else if (op_q == OP_PUT && !found_q) begin
					if (evict_q) valid_q[oidx_q] <= 1'b0;
					valid_q[tgt_q] <= 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data_q <= {7'd0, evicts_n, misses_n, hits_n, puts_n, gets_n,
				SIZE_W'(occ_new), ev_n,
				(hit_n ? 64'(pay_rd_q) : 64'd0), hit_n};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`include "lru_key_value_cache_unit_assert.svh"

	`LKVC_ASSERT(a_occ_bound, clk, arst_n, 32'(occ_q) <= 32'(CAPACITY))
	`LKVC_ASSERT(a_occ_matches_valid, clk, arst_n, 32'(occ_q) == 32'($countones(valid_q)))
	`LKVC_ASSERT_NEXT(a_clear_empties, clk, arst_n, cmd.commit && op_q == OP_CLEAR,
		occ_q == '0 && valid_q == '0)

endmodule

@@ hw/rtl/lru_key_value_cache_unit.sv @@
// Top level of the LRU key-value cache unit.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_dp.
//
//  channel  | signals                         | contents (low bit first)
//  ---------+---------------------------------+------------------------------------
//  s_*      | s_tvalid s_tready s_tdata s_tuser | tdata: key, entry_in; tuser: op
//  m_*      | m_tvalid m_tready m_tdata       | hit, entry_out, evicted, size,
//           |                                 | gets, puts, hits, misses, evictions
//  cfg_*    | cfg_we cfg_wdata                | occupancy limit
//
// A get or put sweeps the entry memories once to find the key, the oldest
// entry and a free slot, then a hit or a put sweeps the recency ranks again;
// a get miss skips the second sweep, and clear or op 3 skip both sweeps.
// Each operation also has an accept step and a commit step.
// The key and rank memories read one entry per cycle, which sets the sweep length.
// Reset clears valid bits, occupancy and counters at once; no clearing pass.
// A result waits in the output register while the next transaction is taken;
// the unit stalls in its commit cycle only while that register is still full.
module lru_key_value_cache_unit import lkvc_pkg::*; #(
	parameter int CAPACITY      = CAPACITY_DEF,
	parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // key[63:0], entry_in[127:64]
	input  logic [1:0]            s_tuser,   // op[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// hit[0], entry_out[64:1], evicted[65], size[72:66], get_count[104:73],
	// put_count[136:105], hit_count[168:137], miss_count[200:169],
	// eviction_count[232:201], zero fill[239:233]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [SIZE_W-1:0]     cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lkvc_dp #(
		.CAPACITY      (CAPACITY),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.in_op     (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
